>>> rtl/lpbp_pkg.sv
// Package for the pinned LRU buffer pool: sizes, opcodes, FSM states.
// No dependencies.
package lpbp_pkg;
   localparam int NumFrames = 16;
   localparam int FrameW = $clog2(NumFrames);
   localparam int CountW = $clog2(NumFrames + 1);
   localparam int TableW = 10;
   localparam int PageW = 32;
   localparam int CapW = 5;

   typedef enum logic [1:0] {
      FUNC_ACCESS = 2'd0,
      FUNC_UNPIN  = 2'd1,
      FUNC_CLOSE  = 2'd2,
      FUNC_FLUSH  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_DECIDE,
      ST_OUT
   } state_type;
endpackage

>>> rtl/lru_pinned_buffer_pool_core.sv
// Top level of the pinned LRU buffer pool: frame directory, sequencer, result register.
// Depends on lpbp_pkg.
//
// One request is taken at a time. An access or unpin passes through a lookup state
// (parallel tag compare over all frames), then a recency scan that walks frame slots
// one per cycle through a shared rank compare, then a decide state and an output
// state. A close or flush repeats a full scan per removed frame, finding the least
// recent matching frame each pass, plus one last pass that finds nothing. Each pass
// waits in the decide state while an earlier result is held by rsp_stall. Results
// leave through one output register; the next request is taken once the last
// result has transferred.
module lru_pinned_buffer_pool_core (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [4:0] csr_write_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_func,
   input  logic [9:0] req_table_id,
   input  logic [31:0] req_page_num,
   input  logic req_dirty,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [3:0] rsp_frame_index,
   output logic rsp_hit,
   output logic rsp_evict_valid,
   output logic rsp_writeback,
   output logic [9:0] rsp_out_table,
   output logic [31:0] rsp_out_page,
   output logic rsp_error,
   output logic rsp_last
);
   import lpbp_pkg::*;

   state_type state_ff, state_in;
   logic [CapW-1:0] cap_ff;
   logic [NumFrames-1:0] valid_ff, valid_in, pin_ff, pin_in, dirty_ff, dirty_in;
   logic [TableW-1:0] tab_ff [NumFrames];
   logic [PageW-1:0] page_ff [NumFrames];
   logic [FrameW-1:0] rank_ff [NumFrames];
   logic [CountW-1:0] occ_ff, occ_in;

   // latched request
   logic [1:0] func_ff;
   logic [TableW-1:0] rtab_ff;
   logic [PageW-1:0] rpage_ff;
   logic rdirty_ff;

   // lookup result and scan state
   logic hit_ff, hit_in;
   logic [FrameW-1:0] hidx_ff, hidx_in;
   logic [FrameW-1:0] scan_ff, scan_in;
   logic found_ff, found_in;
   logic [FrameW-1:0] best_ff, best_in;
   logic removed_ff, removed_in;

   // output register
   logic ovalid_ff, ovalid_in;
   logic [FrameW-1:0] ofi_ff, ofi_in;
   logic ohit_ff, ohit_in, oev_ff, oev_in, owb_ff, owb_in, oerr_ff, oerr_in;
   logic olast_ff, olast_in;
   logic [TableW-1:0] otab_ff, otab_in;
   logic [PageW-1:0] opage_ff, opage_in;

   // directory write commands from the sequencer
   logic do_remove, do_mru, do_alloc;
   logic [FrameW-1:0] tgt;

   logic [NumFrames-1:0] match;
   logic [NumFrames-1:0] freev;
   logic [FrameW-1:0] free_idx;
   logic [CountW-1:0] cap_eff;
   logic cand;
   logic [FrameW-1:0] sc;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_frame_index = ofi_ff;
   assign rsp_hit = ohit_ff;
   assign rsp_evict_valid = oev_ff;
   assign rsp_writeback = owb_ff;
   assign rsp_out_table = otab_ff;
   assign rsp_out_page = opage_ff;
   assign rsp_error = oerr_ff;
   assign rsp_last = olast_ff;

   always_comb begin
      cap_eff = CountW'(NumFrames);
      if (cap_ff == '0) cap_eff = CountW'(1);
      else if ({1'b0, cap_ff} < 6'(NumFrames)) cap_eff = CountW'(cap_ff);
   end

   // parallel tag compare and free-frame priority pick
   always_comb begin
      free_idx = '0;
      for (int i = 0; i < NumFrames; i++) begin
         match[i] = valid_ff[i] && tab_ff[i] == rtab_ff && page_ff[i] == rpage_ff;
         freev[i] = !valid_ff[i];
      end
      for (int i = NumFrames - 1; i >= 0; i--) begin
         if (freev[i]) free_idx = FrameW'(i);
      end
   end

   // shared scan compare: candidate at slot scan_ff
   always_comb begin
      sc = scan_ff;
      if (func_ff == FUNC_ACCESS) cand = valid_ff[sc] && !pin_ff[sc];
      else if (func_ff == FUNC_CLOSE) cand = valid_ff[sc] && tab_ff[sc] == rtab_ff;
      else cand = valid_ff[sc];
   end

   always_comb begin
      state_in = state_ff;
      hit_in = hit_ff;
      hidx_in = hidx_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      best_in = best_ff;
      removed_in = removed_ff;
      ovalid_in = ovalid_ff;
      ofi_in = ofi_ff;
      ohit_in = ohit_ff;
      oev_in = oev_ff;
      owb_in = owb_ff;
      otab_in = otab_ff;
      opage_in = opage_ff;
      oerr_in = oerr_ff;
      olast_in = olast_ff;
      do_remove = 1'b0;
      do_mru = 1'b0;
      do_alloc = 1'b0;
      tgt = best_ff;
      if (ovalid_ff && !rsp_stall) ovalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
               removed_in = 1'b0;
            end
         end
         ST_LOOKUP: begin
            hit_in = |match;
            hidx_in = '0;
            for (int i = 0; i < NumFrames; i++) begin
               if (match[i]) hidx_in = FrameW'(i);
            end
            scan_in = '0;
            found_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // advance one slot per cycle, keep lowest rank candidate
            if (cand && (!found_ff || rank_ff[sc] < rank_ff[best_ff])) begin
               found_in = 1'b1;
               best_in = sc;
            end
            if (scan_ff == FrameW'(NumFrames - 1)) state_in = ST_DECIDE;
            else scan_in = scan_ff + 1'b1;
         end
         ST_DECIDE: begin
            if (!ovalid_ff || !rsp_stall) begin
               ovalid_in = 1'b1;
               ofi_in = '0;
               ohit_in = 1'b0;
               oev_in = 1'b0;
               owb_in = 1'b0;
               otab_in = '0;
               opage_in = '0;
               oerr_in = 1'b0;
               olast_in = 1'b1;
               state_in = ST_OUT;
               if (func_ff == FUNC_UNPIN) begin
                  ohit_in = hit_ff;
                  ofi_in = hit_ff ? hidx_ff : '0;
               end else if (func_ff == FUNC_ACCESS) begin
                  if (hit_ff) begin
                     ohit_in = 1'b1;
                     ofi_in = hidx_ff;
                     do_mru = 1'b1;
                     tgt = hidx_ff;
                  end else if (occ_ff >= cap_eff) begin
                     if (!found_ff) oerr_in = 1'b1;
                     else begin
                        ofi_in = best_ff;
                        oev_in = 1'b1;
                        owb_in = dirty_ff[best_ff];
                        otab_in = tab_ff[best_ff];
                        opage_in = page_ff[best_ff];
                        do_remove = 1'b1;
                        do_alloc = 1'b1;
                        tgt = best_ff;
                     end
                  end else if (!(|freev)) oerr_in = 1'b1;
                  else begin
                     ofi_in = free_idx;
                     do_alloc = 1'b1;
                     tgt = free_idx;
                  end
               end else begin
                  // sweep: emit one removal per pass, last when none left
                  if (found_ff) begin
                     ofi_in = best_ff;
                     oev_in = 1'b1;
                     owb_in = dirty_ff[best_ff];
                     otab_in = tab_ff[best_ff];
                     opage_in = page_ff[best_ff];
                     olast_in = 1'b0;
                     do_remove = 1'b1;
                     removed_in = 1'b1;
                     scan_in = '0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end else if (removed_ff) begin
                     // nothing more: previous result must carry last; drop
                     ovalid_in = ovalid_ff && rsp_stall;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!ovalid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sweeps need last on the final removal; look ahead by counting remaining matches.
   logic [CountW-1:0] left_cnt;
   always_comb begin
      left_cnt = '0;
      for (int i = 0; i < NumFrames; i++) begin
         if (valid_ff[i] && (func_ff == FUNC_FLUSH || tab_ff[i] == rtab_ff))
            left_cnt = left_cnt + 1'b1;
      end
   end

   // directory update
   always_comb begin
      valid_in = valid_ff;
      pin_in = pin_ff;
      dirty_in = dirty_ff;
      occ_in = occ_ff;
      if (state_ff == ST_DECIDE && func_ff == FUNC_UNPIN && hit_ff
            && (!ovalid_ff || !rsp_stall))
         pin_in[hidx_ff] = 1'b0;
      if (do_remove) begin
         valid_in[tgt] = 1'b0;
         pin_in[tgt] = 1'b0;
         dirty_in[tgt] = 1'b0;
         occ_in = occ_ff - 1'b1;
      end
      if (do_mru) begin
         pin_in[tgt] = 1'b1;
         if (rdirty_ff) dirty_in[tgt] = 1'b1;
      end
      if (do_alloc) begin
         valid_in[tgt] = 1'b1;
         pin_in[tgt] = 1'b1;
         dirty_in[tgt] = rdirty_ff;
         occ_in = do_remove ? occ_ff : occ_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff <= CapW'(16);
         valid_ff <= '0;
         pin_ff <= '0;
         dirty_ff <= '0;
         occ_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) cap_ff <= csr_write_data;
         valid_ff <= valid_in;
         pin_ff <= pin_in;
         dirty_ff <= dirty_in;
         occ_ff <= occ_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         func_ff <= req_func;
         rtab_ff <= req_table_id;
         rpage_ff <= req_page_num;
         rdirty_ff <= req_dirty;
      end
      hit_ff <= hit_in;
      hidx_ff <= hidx_in;
      scan_ff <= scan_in;
      found_ff <= found_in;
      best_ff <= best_in;
      removed_ff <= removed_in;
      ofi_ff <= ofi_in;
      ohit_ff <= ohit_in;
      oev_ff <= oev_in;
      owb_ff <= owb_in;
      otab_ff <= otab_in;
      opage_ff <= opage_in;
      oerr_ff <= oerr_in;
      // a sweep removal is final when it takes the last matching frame
      olast_ff <= (do_remove && !do_alloc) ? (left_cnt == CountW'(1)) : olast_in;
      if (do_alloc) begin
         tab_ff[tgt] <= rtab_ff;
         page_ff[tgt] <= rpage_ff;
      end
      // recency: close the gap above a removed or promoted frame
      for (int j = 0; j < NumFrames; j++) begin
         if ((do_remove || do_mru) && valid_ff[j] && rank_ff[j] > rank_ff[tgt])
            rank_ff[j] <= rank_ff[j] - 1'b1;
      end
      if (do_mru) rank_ff[tgt] <= FrameW'(occ_ff - 1'b1);
      else if (do_alloc) rank_ff[tgt] <= FrameW'(do_remove ? occ_ff - 1'b1 : occ_ff);
   end

   assert property (@(posedge clock) disable iff (reset)
      occ_ff == CountW'($countones(valid_ff)))
      else $error("occupancy out of step with valid frames");
   assert property (@(posedge clock) disable iff (reset)
      (pin_ff & ~valid_ff) == '0)
      else $error("pin set on an empty frame");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_evict_valid && rsp_last)
      else $error("error result reports a removal");
endmodule
